// ----- hdl/fpvn_pkg.sv -----
// Package: default widths for the fixed-point vector normalizer.
package fpvn_pkg;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 13;
endpackage

// ----- hdl/fixed_point_vector_normalize.sv -----
// Top level: pipelined fixed-point 3D vector normalizer.
// One vector word is taken every cycle while the output is not stalled,
// and its unit vector passes through the sign, square and sum registers,
// the square root stages, the divider stages and the output register.
// The square root resolves one root bit per stage and is followed by the
// three dividers, which resolve one quotient bit per stage. Throughput is
// one word per cycle when not stalled. A stalled output freezes the whole
// pipeline. A square sum that is zero or negative after wrap gives a zero
// vector with status 1. Quotients saturate.
module fixed_point_vector_normalize #(
  parameter int DATA_WIDTH = fpvn_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS = fpvn_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_x,
  input  logic signed [DATA_WIDTH-1:0] in_y,
  input  logic signed [DATA_WIDTH-1:0] in_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_x,
  output logic signed [DATA_WIDTH-1:0] out_y,
  output logic signed [DATA_WIDTH-1:0] out_z,
  output logic                         status
);
  localparam int W = DATA_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int NB0 = W - 1 + F;
  localparam int NB = (NB0 % 2 == 1) ? NB0 + 1 : NB0;
  localparam int NS = NB / 2;
  localparam int RW = NS + 3;
  localparam int QN = W + F;
  localparam int DW = W + F;
  localparam int P = 2 + NS + QN;
  localparam logic [W:0] LIM = {2'b01, {(W-1){1'b0}}};

  logic en;
  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  // side data along the whole pipe
  logic         v_r   [0:P];
  logic         deg_r [0:P];
  logic         neg_r [0:P][3];
  logic [W-1:0] sz_r  [0:P][3];

  logic [W-1:0] in_c [3];
  assign in_c[0] = in_x;
  assign in_c[1] = in_y;
  assign in_c[2] = in_z;

  // stage 0: sign and size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      deg_r[0] <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        neg_r[0][c] <= in_c[c][W-1];
        sz_r[0][c] <= in_c[c][W-1] ? (~in_c[c] + 1'b1) : in_c[c];
      end
    end
  end

  // stage 1: squares
  logic [2*W-1:0] sq [3];
  logic [W-1:0] term_r [3];
  always_comb begin
    for (int c = 0; c < 3; c++) sq[c] = sz_r[0][c] * sz_r[0][c];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) term_r[c] <= sq[c][F +: W];
    end
  end

  // stage 2: wrapped sum, feeds the root pipe
  logic [NB-1:0] sr_rad  [0:NS];
  logic [RW-1:0] sr_rem  [0:NS];
  logic [NS-1:0] sr_root [0:NS];
  logic [W-1:0] sum;
  assign sum = term_r[0] + term_r[1] + term_r[2];
  always_ff @(posedge clk) begin
    if (en) begin
      sr_rad[0] <= NB'({sum[W-2:0], {F{1'b0}}});
      sr_rem[0] <= '0;
      sr_root[0] <= '0;
    end
  end

  // pipe of side data through all stages past stage 0
  for (genvar p = 1; p <= P; p++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[p] <= 1'b0;
      end else if (en) begin
        v_r[p] <= v_r[p-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (p == 2) begin
          deg_r[p] <= (sum == '0) || sum[W-1];
        end else begin
          deg_r[p] <= deg_r[p-1];
        end
        for (int c = 0; c < 3; c++) begin
          neg_r[p][c] <= neg_r[p-1][c];
          sz_r[p][c] <= sz_r[p-1][c];
        end
      end
    end
  end

  // square root, one bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [RW-1:0] remx, trial;
    assign remx = {sr_rem[k][RW-3:0], sr_rad[k][NB-1:NB-2]};
    assign trial = RW'({sr_root[k], 2'b01});
    always_ff @(posedge clk) begin
      if (en) begin
        sr_rad[k+1] <= {sr_rad[k][NB-3:0], 2'b00};
        if (remx >= trial) begin
          sr_rem[k+1] <= remx - trial;
          sr_root[k+1] <= {sr_root[k][NS-2:0], 1'b1};
        end else begin
          sr_rem[k+1] <= remx;
          sr_root[k+1] <= {sr_root[k][NS-2:0], 1'b0};
        end
      end
    end
  end

  // restoring dividers, one quotient bit per stage
  logic [NS-1:0] dv_mag [0:QN];
  logic [NS-1:0] dv_rem [0:QN][3];
  logic [W:0]    dv_q   [0:QN][3];
  logic [DW-1:0] dv_dd  [0:QN][3];
  assign dv_mag[0] = (sr_root[NS] == '0) ? NS'(1) : sr_root[NS];
  for (genvar c = 0; c < 3; c++) begin : g_dv0
    assign dv_rem[0][c] = '0;
    assign dv_q[0][c] = '0;
    assign dv_dd[0][c] = {sz_r[2+NS][c], {F{1'b0}}};
  end
  for (genvar j = 0; j < QN; j++) begin : g_div
    for (genvar c = 0; c < 3; c++) begin : g_lane
      logic [NS:0] remx;
      logic ge;
      logic [W:0] qn;
      assign remx = {dv_rem[j][c], dv_dd[j][c][DW-1]};
      assign ge = remx >= {1'b0, dv_mag[j]};
      always_comb begin
        qn = {dv_q[j][c][W-1:0], ge};
        if (qn > LIM) qn = LIM + 1'b1;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dv_dd[j+1][c] <= {dv_dd[j][c][DW-2:0], 1'b0};
          dv_rem[j+1][c] <= ge ? NS'(remx - {1'b0, dv_mag[j]}) : remx[NS-1:0];
          dv_q[j+1][c] <= qn;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) dv_mag[j+1] <= dv_mag[j];
    end
  end

  // output word
  logic [W-1:0] res [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (deg_r[P]) begin
        res[c] = '0;
      end else if (neg_r[P][c]) begin
        res[c] = (dv_q[QN][c] > LIM) ? LIM[W-1:0] : W'(~dv_q[QN][c] + 1'b1);
      end else begin
        res[c] = (dv_q[QN][c] >= LIM) ? W'(LIM - 1'b1) : dv_q[QN][c][W-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[P];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= res[0];
      out_y <= res[1];
      out_z <= res[2];
      status <= deg_r[P];
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("degenerate word with nonzero vector");
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output stall");
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[P] && en |=> out_valid)
    else $error("word lost at output register");
endmodule

// ----- tb/tb.sv -----
// Testbench for the pipelined fixed-point 3D vector normalizer.
`timescale 1ns / 1ps
module tb;
  localparam int DW = fpvn_pkg::DATA_WIDTH_DEF;
  localparam int FB = fpvn_pkg::FRAC_BITS_DEF;
  localparam int LATENCY = 2 + (DW - 1 + FB + 1) / 2 + (DW + FB) + 1;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic                 degenerate;
  } unit_vec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DW-1:0] in_x = '0;
  logic signed [DW-1:0] in_y = '0;
  logic signed [DW-1:0] in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_x;
  logic signed [DW-1:0] out_y;
  logic signed [DW-1:0] out_z;
  logic status;

  unit_vec_t expected_units[$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  bit hold_output = 1'b0;
  bit drain_started = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fixed_point_vector_normalize u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z), .status(status)
  );

  function automatic logic [DW-1:0] abs_size(logic signed [DW-1:0] v);
    return v[DW-1] ? -v : v;
  endfunction

  function automatic logic [DW-1:0] sat_quotient(logic neg, logic [DW-1:0] size,
                                                 logic [DW-1:0] mag);
    logic [DW+FB-1:0] num;
    logic [DW+FB-1:0] q;
    num = {size, {FB{1'b0}}};
    q = num / mag;
    if (neg) begin
      if (q > (1 << (DW - 1))) return {1'b1, {(DW-1){1'b0}}};
      return -q[DW-1:0];
    end
    if (q >= (1 << (DW - 1))) return {1'b0, {(DW-1){1'b1}}};
    return q[DW-1:0];
  endfunction

  function automatic unit_vec_t normalize(logic signed [DW-1:0] x,
                                          logic signed [DW-1:0] y,
                                          logic signed [DW-1:0] z);
    unit_vec_t r;
    logic [DW-1:0] sx, sy, sz, sum;
    logic [2*DW-1:0] sq;
    logic [DW+FB-1:0] rad, root, trial;
    sx = abs_size(x);
    sy = abs_size(y);
    sz = abs_size(z);
    sq = sx * sx;
    sum = sq >> FB;
    sq = sy * sy;
    sum = sum + (sq >> FB);
    sq = sz * sz;
    sum = sum + (sq >> FB);
    r = '0;
    if (sum == 0 || sum[DW-1]) begin
      r.degenerate = 1'b1;
      return r;
    end
    rad = {sum, {FB{1'b0}}};
    root = '0;
    for (int b = (DW + FB) / 2; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= rad) root = trial;
    end
    if (root == 0) root = 1;
    r.x = sat_quotient(x[DW-1], sx, root[DW-1:0]);
    r.y = sat_quotient(y[DW-1], sy, root[DW-1:0]);
    r.z = sat_quotient(z[DW-1], sz, root[DW-1:0]);
    return r;
  endfunction

  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1 << 16) << FB;
      1: return -($urandom_range(0, 1 << 16) << FB);
      2: return $urandom_range(0, 4095) - 2048;
      3: return $urandom_range(0, 1 << 22) - (1 << 21);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vector(logic signed [DW-1:0] x, logic signed [DW-1:0] y,
                             logic signed [DW-1:0] z, bit with_gaps);
    int gap;
    gap = with_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_units.push_back(normalize(x, y, z));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_units.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [DW-1:0] edge_vals[8];
    edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0000_2000, 32'hFFFF_E000, 32'h0000_B505};
    foreach (edge_vals[i])
      send_vector(edge_vals[i], edge_vals[i], edge_vals[i], 1'b0);
    send_vector(32'h2000, 0, 0, 1'b0);
    send_vector(0, 32'hFFFF_E000, 0, 1'b0);
    send_vector(0, 0, 32'h8000_0000, 1'b0);
    send_vector(32'h8000_0000, 0, 0, 1'b0);
    send_vector(1, 0, 0, 1'b0);
    send_vector(32'hFFFF_FFFF, 0, 0, 1'b0);
    send_vector(32'h80, 32'h7FFF_FFFF, 1, 1'b0);
    send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_vector(32'h5A82_7999, 32'h0, 32'h0, 1'b0);
    send_vector(32'h0000_0050, 32'hFFFF_FFB0, 32'h0000_0001, 1'b0);
    send_vector(32'h0016_A09E, 32'h0, 32'h0, 1'b0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_vector(rand_word(), rand_word(), rand_word(), (i / 200) % 2 == 0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_output = 1'b1;
    fork
      for (int i = 0; i < 150; i++)
        send_vector(rand_word(), rand_word(), rand_word(), 1'b0);
      begin
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
      end
    join
    wait_drained();
  endtask

  // receiver: after each taken word, draw how many cycles to hold off
  always @(posedge clk) begin
    int rx_draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else if (hold_output) begin
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall) begin
      rx_draw = (drain_started || $urandom_range(0, 3) == 0) ? 0
                                                            : $urandom_range(0, 14);
      rx_wait <= rx_draw;
      out_stall <= (rx_draw != 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= (rx_wait > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    unit_vec_t exp_u;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h status=%b",
                 $time, out_x, out_y, out_z, status);
        errors++;
      end else begin
        exp_u = expected_units.pop_front();
        if (out_x !== exp_u.x) begin
          $display("%0t: out_x expected %h actual %h", $time, exp_u.x, out_x);
          errors++;
        end
        if (out_y !== exp_u.y) begin
          $display("%0t: out_y expected %h actual %h", $time, exp_u.y, out_y);
          errors++;
        end
        if (out_z !== exp_u.z) begin
          $display("%0t: out_z expected %h actual %h", $time, exp_u.z, out_z);
          errors++;
        end
        if (status !== exp_u.degenerate) begin
          $display("%0t: status expected %b actual %b", $time, exp_u.degenerate,
                   status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    test_backpressure();
    test_random(800);
    drain_started = 1'b1;
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_units.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/fpvn_pkg.sv
hdl/fixed_point_vector_normalize.sv
tb/tb.sv
